/* rtl/two_wire_debug_bit_sequencer_defines.svh */
// Assertion helpers used by the sequencer controller.
// Each check runs on the rising clock and is off while reset is held.
`ifndef TWO_WIRE_DEBUG_BIT_SEQUENCER_DEFINES_SVH
`define TWO_WIRE_DEBUG_BIT_SEQUENCER_DEFINES_SVH

// Same-cycle implication.
`define TWDBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TWDBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/twdbs_pkg.sv */
package twdbs_pkg;

  // Command codes.
  localparam logic [2:0] FN_START = 3'd0;
  localparam logic [2:0] FN_WRITE = 3'd1;
  localparam logic [2:0] FN_RDBEG = 3'd2;
  localparam logic [2:0] FN_RDBIT = 3'd3;
  localparam logic [2:0] FN_DONE  = 3'd4;

  // Slot kinds.
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_DRIVE  = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;

  // Slots in one frame, and the width of a slot counter.
  localparam int unsigned FRAME_SLOTS = 9;
  localparam int unsigned SLOT_CNT_W  = 4;
  localparam int unsigned BYTE_BITS   = 8;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;   // an input beat is accepted this cycle
    logic emit;   // the next slot moves into the output register
    logic last;   // that slot is the final one of its command
  } dp_cmd_t;

  // Number of slots a command produces; unused codes produce none.
  function automatic logic [SLOT_CNT_W-1:0] slot_count(input logic [2:0] func);
    logic [SLOT_CNT_W-1:0] n;
    n = '0;
    case (func)
      FN_START, FN_WRITE: n = SLOT_CNT_W'(FRAME_SLOTS);
      FN_RDBEG, FN_RDBIT, FN_DONE: n = SLOT_CNT_W'(1);
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

/* rtl/twdbs_ctrl.sv */
module twdbs_ctrl
  import twdbs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] func_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dp_cmd_t    cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SEND = 1'b1;

  logic                  state_q, state_d;
  logic [SLOT_CNT_W-1:0] rem_q, rem_d;
  logic                  out_valid_q, out_valid_d;
  logic [SLOT_CNT_W-1:0] nslots;
  logic                  out_free, emit, accept, final_slot;

  // Handshake decisions for this cycle.
  always_comb begin
    nslots     = slot_count(func_i);
    out_free   = !out_valid_q || out_ready_i;
    emit       = (state_q == ST_SEND) && out_free;
    final_slot = (rem_q == SLOT_CNT_W'(1));
    // The next command may enter while the last slot of this one leaves.
    in_ready_o = (state_q == ST_IDLE) || (emit && final_slot);
    accept     = in_valid_i && in_ready_o;
  end

  // Slot counter and state.
  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    if (accept) begin
      rem_d   = nslots;
      state_d = (nslots != '0) ? ST_SEND : ST_IDLE;
    end else if (emit) begin
      rem_d = rem_q - SLOT_CNT_W'(1);
      if (final_slot) begin
        state_d = ST_IDLE;
      end
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o.load  = accept;
  assign cmd_o.emit  = emit;
  assign cmd_o.last  = final_slot;

`include "two_wire_debug_bit_sequencer_defines.svh"

  `TWDBS_ASSERT_NOW(a_state_matches_count, 1'b1, ((state_q == ST_SEND) == (rem_q != '0)), "state and slot count disagree")
  `TWDBS_ASSERT_NOW(a_count_in_range, 1'b1, (rem_q <= SLOT_CNT_W'(FRAME_SLOTS)), "slot count above frame length")
  `TWDBS_ASSERT_NEXT(a_emit_shows_beat, emit, out_valid_q, "emitted slot not presented")
  `TWDBS_ASSERT_NEXT(a_load_sets_count, accept, (rem_q == $past(nslots)), "slot count not loaded")

endmodule

/* rtl/twdbs_dpath.sv */
module twdbs_dpath
  import twdbs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  input  logic [2:0] func_i,
  input  logic [6:0] reg_addr_i,
  input  logic       read_flag_i,
  input  logic [7:0] write_data_i,
  input  logic       line_in_i,
  output logic [1:0] slot_kind_o,
  output logic       drive_level_o,
  output logic [7:0] read_data_o,
  output logic       read_valid_o,
  output logic       last_o
);

  // Frame of pending slot levels, MSB leaves first.
  logic [FRAME_SLOTS-1:0] lvl_q, lvl_d;
  logic                   first_q, first_d;
  logic [1:0]             kind0_q, kind0_d;
  logic [7:0]             rdata_q, rdata_d;
  logic                   rvalid_q, rvalid_d;

  // Read assembler.
  logic [7:0]            rshift_q, rshift_d;
  logic [SLOT_CNT_W-1:0] rcnt_q, rcnt_d;

  logic [7:0]            shift_in;
  logic [SLOT_CNT_W-1:0] cnt_inc;

  // Output register.
  logic [1:0] kind_q;
  logic       drive_q, rv_q, last_q;
  logic [7:0] rd_q;

  // Load a new frame on an accepted beat, otherwise shift out on emit.
  always_comb begin
    lvl_d    = lvl_q;
    first_d  = first_q;
    kind0_d  = kind0_q;
    rdata_d  = rdata_q;
    rvalid_d = rvalid_q;
    rshift_d = rshift_q;
    rcnt_d   = rcnt_q;
    shift_in = {rshift_q[6:0], line_in_i};
    cnt_inc  = rcnt_q + SLOT_CNT_W'(1);
    if (cmd_i.emit) begin
      lvl_d   = {lvl_q[FRAME_SLOTS-2:0], 1'b0};
      first_d = 1'b0;
    end
    if (cmd_i.load) begin
      first_d  = 1'b1;
      kind0_d  = KIND_DRIVE;
      rdata_d  = '0;
      rvalid_d = 1'b0;
      lvl_d    = '0;
      case (func_i)
        FN_START: begin
          kind0_d = KIND_START;
          lvl_d   = {1'b0, reg_addr_i, read_flag_i};
        end
        FN_WRITE: begin
          lvl_d = {1'b0, write_data_i};
        end
        FN_RDBEG: begin
          rshift_d = '0;
          rcnt_d   = '0;
        end
        FN_RDBIT: begin
          kind0_d = KIND_SAMPLE;
          if (cnt_inc >= SLOT_CNT_W'(BYTE_BITS)) begin
            // Byte complete: report it and start over.
            rdata_d  = shift_in;
            rvalid_d = 1'b1;
            rshift_d = '0;
            rcnt_d   = '0;
          end else begin
            rshift_d = shift_in;
            rcnt_d   = cnt_inc;
          end
        end
        FN_DONE: begin
          lvl_d = {1'b1, {(FRAME_SLOTS-1){1'b0}}};
        end
        default: begin
          first_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= 1'b0;
      rshift_q <= '0;
      rcnt_q   <= '0;
    end else begin
      first_q  <= first_d;
      rshift_q <= rshift_d;
      rcnt_q   <= rcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q    <= lvl_d;
    kind0_q  <= kind0_d;
    rdata_q  <= rdata_d;
    rvalid_q <= rvalid_d;
  end

  // The output register takes the head slot of the frame.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q  <= first_q ? kind0_q : KIND_DRIVE;
      drive_q <= lvl_q[FRAME_SLOTS-1];
      rd_q    <= first_q ? rdata_q : 8'd0;
      rv_q    <= first_q && rvalid_q;
      last_q  <= cmd_i.last;
    end
  end

  assign slot_kind_o   = kind_q;
  assign drive_level_o = drive_q;
  assign read_data_o   = rd_q;
  assign read_valid_o  = rv_q;
  assign last_o        = last_q;

endmodule

/* rtl/two_wire_debug_bit_sequencer.sv */
// Two-wire debug bus master, bit-slot sequencer.
// Input channel: one beat per command (func, reg_addr, read_flag, write_data,
// line_in) under in_valid_i / in_ready_o. Output channel: one beat per bus
// slot (slot_kind, drive_level, read_data, read_valid, last) under
// out_valid_o / out_ready_i; last marks the final slot of a command.
// A start or write-byte command yields nine slots, the other commands one,
// and unused codes are taken with no slot at all.
// An accepted beat loads the frame and slot counter; its first slot then
// moves into the output register. The slot counter emits one slot per cycle
// while the receiver does not stall; the next command is taken in the cycle
// that the final slot of the current one leaves.
// When the receiver stalls, the output register holds its slot and the
// counter waits; a command may still be taken once its predecessor's last
// slot sits in the output register.
// Reset clears the slot counter, the output valid and the read assembler
// (shift register and bit count both zero).
module two_wire_debug_bit_sequencer
  import twdbs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] func_i,
  input  logic [6:0] reg_addr_i,
  input  logic       read_flag_i,
  input  logic [7:0] write_data_i,
  input  logic       line_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] slot_kind_o,
  output logic       drive_level_o,
  output logic [7:0] read_data_o,
  output logic       read_valid_o,
  output logic       last_o
);

  dp_cmd_t cmd;

  twdbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  twdbs_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .func_i        (func_i),
    .reg_addr_i    (reg_addr_i),
    .read_flag_i   (read_flag_i),
    .write_data_i  (write_data_i),
    .line_in_i     (line_in_i),
    .slot_kind_o   (slot_kind_o),
    .drive_level_o (drive_level_o),
    .read_data_o   (read_data_o),
    .read_valid_o  (read_valid_o),
    .last_o        (last_o)
  );

endmodule
